// ===== src/rsw_pkg.sv =====
`default_nettype none
package rsw_pkg;

  // scan shape constants
  localparam int DEAD_POINTS       = 20;
  localparam int PULSE_DELAY       = 10;
  localparam int STAIR_DOWN_FRAMES = 3;
  localparam int MV_LIMIT          = 10000;

  // widths
  localparam int S_W    = 14;  // sample index
  localparam int FI_W   = 12;  // frame index
  localparam int SL_W   = 15;  // line length
  localparam int NF_W   = 13;  // frames per volume
  localparam int AMP_W  = 15;
  localparam int MV_W   = 15;
  localparam int FAC_W  = 16;  // multiplier factor
  localparam int DEN_W  = 16;  // divisor
  localparam int NUM_W  = FAC_W + AMP_W;  // dividend and quotient
  localparam int BASE_W = 17;
  localparam int RES_W  = NUM_W + 2;
  localparam int FD_W   = $clog2(STAIR_DOWN_FRAMES);
  localparam int CNT_W  = $clog2(NUM_W);

  typedef logic [S_W-1:0]           sidx_t;
  typedef logic [FI_W-1:0]          fidx_t;
  typedef logic [SL_W-1:0]          sl_t;
  typedef logic [NF_W-1:0]          nf_t;
  typedef logic [AMP_W-1:0]         amp_t;
  typedef logic signed [MV_W-1:0]   mv_t;
  typedef logic [FAC_W-1:0]         fac_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [NUM_W-1:0]         num_t;
  typedef logic signed [BASE_W-1:0] base_t;
  typedef logic signed [RES_W-1:0]  res_t;
  typedef logic [FD_W-1:0]          fd_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // configuration register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_LINE_POINTS       = 3'd0;
  localparam reg_idx_t REG_FLYBACK_POINTS    = 3'd1;
  localparam reg_idx_t REG_FRAMES_PER_VOLUME = 3'd2;
  localparam reg_idx_t REG_VOLUME_MODE       = 3'd3;
  localparam reg_idx_t REG_X_AMPLITUDE       = 3'd4;
  localparam reg_idx_t REG_X_OFFSET          = 3'd5;
  localparam reg_idx_t REG_Y_AMPLITUDE       = 3'd6;
  localparam reg_idx_t REG_Y_OFFSET          = 3'd7;

  // offsets held as raw two's complement bits
  typedef struct packed {
    logic [13:0] line_points;
    logic [10:0] flyback_points;
    logic [12:0] frames_per_volume;
    logic        volume_mode;
    logic [14:0] x_amplitude;
    logic [14:0] x_offset;
    logic [14:0] y_amplitude;
    logic [14:0] y_offset;
  } cfg_t;

  // one quotient term: value = base +/- (fac * amp) / den, with the quotient zero when den is zero
  typedef struct packed {
    fac_t  fac;
    amp_t  amp;
    den_t  den;
    base_t base;
    logic  neg;
  } term_t;

  function automatic mv_t sat_mv(input res_t v);
    mv_t r;
    if (v > res_t'(MV_LIMIT)) begin
      r = mv_t'(MV_LIMIT);
    end else if (v < -res_t'(MV_LIMIT)) begin
      r = mv_t'(-MV_LIMIT);
    end else begin
      r = v[MV_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/rsw_term.sv =====
`default_nettype none
// Forms the X and Y quotient terms for one sample from the indices and
// the configuration.
module rsw_term (
  input  rsw_pkg::cfg_t  cfg,
  input  rsw_pkg::sidx_t s_idx,
  input  rsw_pkg::fidx_t f_idx,
  input  rsw_pkg::sl_t   sl,
  input  rsw_pkg::nf_t   nf,
  output rsw_pkg::term_t x_term,
  output rsw_pkg::term_t y_term
);

  rsw_pkg::base_t x_top;
  rsw_pkg::base_t x_amp_e;
  rsw_pkg::sl_t   s_pd;
  rsw_pkg::sl_t   x_tot;
  rsw_pkg::sidx_t fly_start;
  logic           in_dead;
  logic           in_ramp;
  logic           in_fly;
  logic           has_ramp;

  rsw_pkg::base_t y_off;
  rsw_pkg::base_t y_half;
  rsw_pkg::nf_t   ds;
  rsw_pkg::nf_t   nf_m1;
  rsw_pkg::fidx_t f_cl;
  rsw_pkg::fd_t   fd;
  rsw_pkg::den_t  j_idx;

  // X: dead span, ramp down, flyback up, closing dead span
  always_comb begin
    x_top   = $signed({{2{cfg.x_offset[14]}}, cfg.x_offset})
            + $signed({3'b000, cfg.x_amplitude[14:1]});
    x_amp_e = $signed({2'b00, cfg.x_amplitude});
    s_pd    = {1'b0, s_idx} + rsw_pkg::sl_t'(rsw_pkg::DEAD_POINTS);
    x_tot   = {1'b0, cfg.line_points} + {4'b0000, cfg.flyback_points};
    in_dead = s_idx < rsw_pkg::sidx_t'(rsw_pkg::DEAD_POINTS);
    in_ramp = !in_dead && (s_pd < {1'b0, cfg.line_points});
    in_fly  = !in_dead && !in_ramp && (s_pd < x_tot);
    has_ramp = cfg.line_points > rsw_pkg::sidx_t'(2 * rsw_pkg::DEAD_POINTS);
    fly_start = has_ramp ?
                cfg.line_points - rsw_pkg::sidx_t'(rsw_pkg::DEAD_POINTS) :
                rsw_pkg::sidx_t'(rsw_pkg::DEAD_POINTS);

    x_term.amp  = cfg.x_amplitude;
    x_term.fac  = '0;
    x_term.den  = '0;
    x_term.base = x_top;
    x_term.neg  = 1'b0;
    if (in_ramp) begin
      x_term.fac = rsw_pkg::fac_t'(s_idx);
      x_term.den = rsw_pkg::den_t'(cfg.line_points
                 - rsw_pkg::sidx_t'(rsw_pkg::DEAD_POINTS + 1));
      x_term.neg = 1'b1;
    end else if (in_fly) begin
      x_term.fac  = rsw_pkg::fac_t'(s_idx - fly_start);
      x_term.den  = rsw_pkg::den_t'(cfg.flyback_points);
      x_term.base = has_ramp ? x_top - x_amp_e : x_top;
    end
  end

  // Y: constant in line mode, staircase then linear ramp down in volume mode
  always_comb begin
    y_off  = $signed({{2{cfg.y_offset[14]}}, cfg.y_offset});
    y_half = $signed({3'b000, cfg.y_amplitude[14:1]});
    ds     = (nf > rsw_pkg::nf_t'(rsw_pkg::STAIR_DOWN_FRAMES)) ?
             nf - rsw_pkg::nf_t'(rsw_pkg::STAIR_DOWN_FRAMES) : '0;
    nf_m1  = nf - rsw_pkg::nf_t'(1);
    f_cl   = ({1'b0, f_idx} > nf_m1) ? nf_m1[rsw_pkg::FI_W-1:0] : f_idx;
    fd     = rsw_pkg::fd_t'({1'b0, f_cl} - ds);
    j_idx  = rsw_pkg::den_t'(fd) * rsw_pkg::den_t'(sl) + rsw_pkg::den_t'(s_idx);

    y_term.amp  = cfg.y_amplitude;
    y_term.fac  = '0;
    y_term.den  = '0;
    y_term.base = y_off;
    y_term.neg  = 1'b0;
    if (cfg.volume_mode) begin
      if ({1'b0, f_cl} < ds) begin
        y_term.fac  = rsw_pkg::fac_t'(f_cl);
        y_term.den  = rsw_pkg::den_t'(nf
                    - rsw_pkg::nf_t'(rsw_pkg::STAIR_DOWN_FRAMES + 1));
        y_term.base = y_off - y_half;
      end else begin
        y_term.fac  = j_idx;
        y_term.den  = rsw_pkg::den_t'(sl)
                    * rsw_pkg::den_t'(rsw_pkg::STAIR_DOWN_FRAMES)
                    - rsw_pkg::den_t'(1);
        y_term.base = y_off + y_half;
        y_term.neg  = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/rsw_div.sv =====
`default_nettype none
// Shared multiply-then-divide unit: the product fac*amp is taken on start,
// then a restoring division retires one quotient bit per cycle.
module rsw_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rsw_pkg::fac_t  fac,
  input  rsw_pkg::amp_t  amp,
  input  rsw_pkg::den_t  den,
  output logic           done,
  output rsw_pkg::num_t  quo
);

  rsw_pkg::num_t quo_sh;
  rsw_pkg::den_t rem;
  rsw_pkg::den_t den_r;
  rsw_pkg::cnt_t cnt;
  logic          running;

  logic [rsw_pkg::DEN_W:0] shifted;
  logic                    ge;

  // trial subtract
  always_comb begin
    shifted = {rem, quo_sh[rsw_pkg::NUM_W-1]};
    ge      = shifted >= {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= rsw_pkg::cnt_t'(rsw_pkg::NUM_W - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - rsw_pkg::cnt_t'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= rsw_pkg::num_t'(fac) * rsw_pkg::num_t'(amp);
      rem    <= '0;
      den_r  <= den;
    end else if (running) begin
      quo_sh <= {quo_sh[rsw_pkg::NUM_W-2:0], ge};
      rem    <= ge ? rsw_pkg::den_t'(shifted - {1'b0, den_r}) :
                     shifted[rsw_pkg::DEN_W-1:0];
    end
  end

  // zero divisor gives a zero quotient
  assign quo = (den_r == '0) ? '0 : quo_sh;

endmodule
`default_nettype wire

// ===== src/raster_scan_waveform_generator.sv =====
`default_nettype none
// Galvo raster scan sample generator.
// Each transfer on the slave stream (s_tdata bit 0 = restart) asks for one
// scan sample; restart high jumps to sample 0 of frame 0 first. One result
// transfer follows on the master stream: X and Y drive in millivolts, the
// camera trigger level, tlast on the last sample of a line and tuser on
// the last sample of a volume (of every line in line mode).
// The configuration port writes one register per cycle with cfg_we; write
// only while no sample is in progress.
// The result is formed by the shared multiply-divide unit, run once for X
// and once for Y between the PREP, XLOAD, YLOAD and OUT sequencing
// states; a new input is taken only once the sequencer is back in idle.
// s_tready is high only while the sequencer is idle. A finished result
// waits in the output register while m_tready is low, and the next input
// may be taken meanwhile; its result is held back until the first leaves.
// Reset restores the register defaults, clears the scan position to
// sample 0 of frame 0 and empties the output register.
module raster_scan_waveform_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [14:0] x_mv, [29:15] y_mv, [30] camera_trigger, [31] zero
  output logic        m_tlast,   // line_end
  output logic        m_tuser,   // volume_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_XLOAD = 3'd2;
  localparam logic [2:0] ST_XDIV  = 3'd3;
  localparam logic [2:0] ST_YLOAD = 3'd4;
  localparam logic [2:0] ST_YDIV  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]     state;
  rsw_pkg::cfg_t  cfg;
  rsw_pkg::sidx_t sample_index;
  rsw_pkg::fidx_t frame_index;

  rsw_pkg::sidx_t s_w;
  rsw_pkg::fidx_t f_w;
  logic           trig_w;
  logic           lend_w;
  logic           vend_w;
  rsw_pkg::mv_t   x_res;
  rsw_pkg::mv_t   y_res;
  rsw_pkg::term_t x_t_r;
  rsw_pkg::term_t y_t_r;
  rsw_pkg::term_t x_term;
  rsw_pkg::term_t y_term;
  rsw_pkg::term_t div_term;
  rsw_pkg::term_t cur_term;

  rsw_pkg::sl_t   sl;
  rsw_pkg::nf_t   nf;
  rsw_pkg::sl_t   x_tot;
  rsw_pkg::sidx_t s_cur;
  rsw_pkg::fidx_t f_cur;
  logic           lend;
  logic           vend;
  logic           trig;
  logic           in_xfer;
  logic           div_start;
  logic           div_done;
  rsw_pkg::num_t  div_quo;
  rsw_pkg::res_t  base_e;
  rsw_pkg::res_t  q_e;
  rsw_pkg::res_t  sum;
  rsw_pkg::mv_t   sat_val;

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  // line length and frame count, clamped
  always_comb begin
    x_tot = {1'b0, cfg.line_points} + {4'b0000, cfg.flyback_points};
    if (x_tot == '0) begin
      sl = rsw_pkg::sl_t'(1);
    end else if (x_tot > rsw_pkg::sl_t'(16384)) begin
      sl = rsw_pkg::sl_t'(16384);
    end else begin
      sl = x_tot;
    end
    if (cfg.frames_per_volume == '0) begin
      nf = rsw_pkg::nf_t'(1);
    end else if (cfg.frames_per_volume > rsw_pkg::nf_t'(4096)) begin
      nf = rsw_pkg::nf_t'(4096);
    end else begin
      nf = cfg.frames_per_volume;
    end
  end

  // position and flags of the sample being requested
  always_comb begin
    s_cur = s_tdata[0] ? '0 : sample_index;
    f_cur = (s_tdata[0] || !cfg.volume_mode) ? '0 : frame_index;
    lend  = {1'b0, s_cur} >= sl - rsw_pkg::sl_t'(1);
    vend  = lend && (!cfg.volume_mode || ({1'b0, f_cur} >= nf - rsw_pkg::nf_t'(1)));
    trig  = (s_cur >= rsw_pkg::sidx_t'(rsw_pkg::PULSE_DELAY))
         && ({1'b0, s_cur} < (sl >> 1));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_points       <= 14'd1024;
      cfg.flyback_points    <= 11'd100;
      cfg.frames_per_volume <= 13'd256;
      cfg.volume_mode       <= 1'b0;
      cfg.x_amplitude       <= 15'd2000;
      cfg.x_offset          <= 15'd0;
      cfg.y_amplitude       <= 15'd2000;
      cfg.y_offset          <= 15'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsw_pkg::REG_LINE_POINTS:       cfg.line_points       <= cfg_data[13:0];
        rsw_pkg::REG_FLYBACK_POINTS:    cfg.flyback_points    <= cfg_data[10:0];
        rsw_pkg::REG_FRAMES_PER_VOLUME: cfg.frames_per_volume <= cfg_data[12:0];
        rsw_pkg::REG_VOLUME_MODE:       cfg.volume_mode       <= cfg_data[0];
        rsw_pkg::REG_X_AMPLITUDE:       cfg.x_amplitude       <= cfg_data;
        rsw_pkg::REG_X_OFFSET:          cfg.x_offset          <= cfg_data;
        rsw_pkg::REG_Y_AMPLITUDE:       cfg.y_amplitude       <= cfg_data;
        rsw_pkg::REG_Y_OFFSET:          cfg.y_offset          <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan position, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      frame_index  <= '0;
    end else if (in_xfer) begin
      if (lend) begin
        sample_index <= '0;
        frame_index  <= vend ? '0 : f_cur + rsw_pkg::fidx_t'(1);
      end else begin
        sample_index <= s_cur + rsw_pkg::sidx_t'(1);
        frame_index  <= f_cur;
      end
    end
  end

  // operand formation
  rsw_term u_term (
    .cfg    (cfg),
    .s_idx  (s_w),
    .f_idx  (f_w),
    .sl     (sl),
    .nf     (nf),
    .x_term (x_term),
    .y_term (y_term)
  );

  assign div_start = (state == ST_XLOAD) || (state == ST_YLOAD);
  assign div_term  = (state == ST_YLOAD) ? y_t_r : x_t_r;

  rsw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .fac   (div_term.fac),
    .amp   (div_term.amp),
    .den   (div_term.den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // base +/- quotient, then saturation
  always_comb begin
    cur_term = (state == ST_YDIV) ? y_t_r : x_t_r;
    base_e   = {{(rsw_pkg::RES_W - rsw_pkg::BASE_W){cur_term.base[rsw_pkg::BASE_W-1]}},
                cur_term.base};
    q_e      = $signed({{(rsw_pkg::RES_W - rsw_pkg::NUM_W){1'b0}}, div_quo});
    sum      = cur_term.neg ? base_e - q_e : base_e + q_e;
    sat_val  = rsw_pkg::sat_mv(sum);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // result taken; in ST_OUT the next one may replace it at once
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_PREP;
          end
        end
        ST_PREP:  state <= ST_XLOAD;
        ST_XLOAD: state <= ST_XDIV;
        ST_XDIV: begin
          if (div_done) begin
            state <= ST_YLOAD;
          end
        end
        ST_YLOAD: state <= ST_YDIV;
        ST_YDIV: begin
          if (div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // work registers and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_w    <= s_cur;
      f_w    <= f_cur;
      trig_w <= trig;
      lend_w <= lend;
      vend_w <= vend;
    end
    if (state == ST_PREP) begin
      x_t_r <= x_term;
      y_t_r <= y_term;
    end
    if (state == ST_XDIV && div_done) begin
      x_res <= sat_val;
    end
    if (state == ST_YDIV && div_done) begin
      y_res <= sat_val;
    end
    // payload changes only once the previous result has left
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, trig_w, y_res, x_res};
      m_tlast <= lend_w;
      m_tuser <= vend_w;
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // one scan sample as it leaves the block
  typedef struct packed {
    rsw_pkg::mv_t x_mv;
    rsw_pkg::mv_t y_mv;
    logic         camera_trigger;
    logic         line_end;
    logic         volume_end;
  } scan_sample_t;

  // Tracks the scan position and register copy, works out each sample
  // and matches the result stream against the samples still due.
  class scan_checker;
    rsw_pkg::cfg_t  cfg;
    rsw_pkg::sidx_t sample_idx;
    rsw_pkg::fidx_t frame_idx;
    scan_sample_t   due_samples[$];
    int             errors;
    int             requests;
    int             restarts;
    int             checked;
    int             line_ends;
    int             volume_ends;

    function new();
      cfg.line_points       = 14'd1024;
      cfg.flyback_points    = 11'd100;
      cfg.frames_per_volume = 13'd256;
      cfg.volume_mode       = 1'b0;
      cfg.x_amplitude       = 15'd2000;
      cfg.x_offset          = '0;
      cfg.y_amplitude       = 15'd2000;
      cfg.y_offset          = '0;
      sample_idx = '0;
      frame_idx  = '0;
    endfunction

    // written value is cut to the register width
    function void set_register(rsw_pkg::reg_idx_t idx, logic [14:0] value);
      case (idx)
        rsw_pkg::REG_LINE_POINTS:       cfg.line_points       = value[13:0];
        rsw_pkg::REG_FLYBACK_POINTS:    cfg.flyback_points    = value[10:0];
        rsw_pkg::REG_FRAMES_PER_VOLUME: cfg.frames_per_volume = value[12:0];
        rsw_pkg::REG_VOLUME_MODE:       cfg.volume_mode       = value[0];
        rsw_pkg::REG_X_AMPLITUDE:       cfg.x_amplitude       = value;
        rsw_pkg::REG_X_OFFSET:          cfg.x_offset          = value;
        rsw_pkg::REG_Y_AMPLITUDE:       cfg.y_amplitude       = value;
        rsw_pkg::REG_Y_OFFSET:          cfg.y_offset          = value;
        default: ;
      endcase
    endfunction

    // truncating quotient, zero for a zero or negative divisor
    function longint ratio(longint num, longint den);
      return (den <= 0) ? 0 : num / den;
    endfunction

    function rsw_pkg::mv_t clamp_mv(longint v);
      if (v > rsw_pkg::MV_LIMIT) v = rsw_pkg::MV_LIMIT;
      if (v < -rsw_pkg::MV_LIMIT) v = -rsw_pkg::MV_LIMIT;
      return rsw_pkg::mv_t'(v);
    endfunction

    // work out the sample for one request and step the scan position
    function void advance_scan(logic restart);
      longint       lp, fb, line_len, frames, s, f;
      longint       ax, ay, top, ramp_end, start, base, xv, yv, down_start;
      bit           has_ramp;
      scan_sample_t want;
      lp = longint'(cfg.line_points);
      fb = longint'(cfg.flyback_points);
      line_len = lp + fb;
      if (line_len < 1) line_len = 1;
      if (line_len > 16384) line_len = 16384;
      frames = longint'(cfg.frames_per_volume);
      if (frames < 1) frames = 1;
      if (frames > 4096) frames = 4096;

      requests++;
      if (restart) begin
        sample_idx = '0;
        frame_idx  = '0;
        restarts++;
      end
      if (!cfg.volume_mode) frame_idx = '0;
      s = longint'(sample_idx);
      f = longint'(frame_idx);

      want.line_end   = (s >= line_len - 1);
      want.volume_end = want.line_end && (!cfg.volume_mode || f >= frames - 1);
      want.camera_trigger = (s >= rsw_pkg::PULSE_DELAY) && (s < line_len / 2);

      // X sawtooth: dead span, ramp down, flyback up, dead span
      ax = longint'(cfg.x_amplitude);
      top = longint'($signed(cfg.x_offset)) + ax / 2;
      ramp_end = lp - rsw_pkg::DEAD_POINTS;
      has_ramp = ramp_end > rsw_pkg::DEAD_POINTS;
      if (s < rsw_pkg::DEAD_POINTS) begin
        xv = top;
      end else if (s < ramp_end) begin
        xv = top - ratio(s * ax, lp - rsw_pkg::DEAD_POINTS - 1);
      end else if (s < lp + fb - rsw_pkg::DEAD_POINTS) begin
        start = has_ramp ? ramp_end : rsw_pkg::DEAD_POINTS;
        base  = (has_ramp && lp - rsw_pkg::DEAD_POINTS - 1 > 0) ? top - ax : top;
        xv = base + ratio((s - start) * ax, fb);
      end else begin
        xv = top;
      end

      // Y: constant in line mode, staircase with a ramp back down otherwise
      ay = longint'(cfg.y_amplitude);
      down_start = (frames > rsw_pkg::STAIR_DOWN_FRAMES) ?
                   frames - rsw_pkg::STAIR_DOWN_FRAMES : 0;
      if (!cfg.volume_mode) begin
        yv = longint'($signed(cfg.y_offset));
      end else begin
        if (f > frames - 1) f = frames - 1;
        if (f < down_start) begin
          yv = longint'($signed(cfg.y_offset)) - ay / 2
               + ratio(f * ay, frames - rsw_pkg::STAIR_DOWN_FRAMES - 1);
        end else begin
          yv = longint'($signed(cfg.y_offset)) + ay / 2
               - ratio(((f - down_start) * line_len + s) * ay,
                       line_len * rsw_pkg::STAIR_DOWN_FRAMES - 1);
        end
      end
      want.x_mv = clamp_mv(xv);
      want.y_mv = clamp_mv(yv);
      due_samples.push_back(want);
      if (want.line_end) line_ends++;
      if (want.volume_end) volume_ends++;

      // step position
      if (want.line_end) begin
        sample_idx = '0;
        if (want.volume_end) frame_idx = '0;
        else frame_idx = frame_idx + 1'b1;
      end else begin
        sample_idx = sample_idx + 1'b1;
      end
    endfunction

    function void match_sample(scan_sample_t got);
      scan_sample_t want;
      if (due_samples.size() == 0) begin
        $error("result transfer with no sample due: x_mv %0d y_mv %0d",
               $signed(got.x_mv), $signed(got.y_mv));
        errors++;
        return;
      end
      want = due_samples.pop_front();
      checked++;
      if (got.x_mv !== want.x_mv) begin
        $error("x_mv: expected %0d, got %0d", $signed(want.x_mv), $signed(got.x_mv));
        errors++;
      end
      if (got.y_mv !== want.y_mv) begin
        $error("y_mv: expected %0d, got %0d", $signed(want.y_mv), $signed(got.y_mv));
        errors++;
      end
      if (got.camera_trigger !== want.camera_trigger) begin
        $error("camera_trigger: expected %0b, got %0b",
               want.camera_trigger, got.camera_trigger);
        errors++;
      end
      if (got.line_end !== want.line_end) begin
        $error("line_end: expected %0b, got %0b", want.line_end, got.line_end);
        errors++;
      end
      if (got.volume_end !== want.volume_end) begin
        $error("volume_end: expected %0b, got %0b", want.volume_end, got.volume_end);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_data;

  scan_checker sb;
  int          sink_hold;
  bit          calm;
  int          settings;

  raster_scan_waveform_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [0] restart
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [14:0] x_mv, [29:15] y_mv, [30] camera_trigger
    .m_tlast   (m_tlast),    // line_end
    .m_tuser   (m_tuser),    // volume_end
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // transfer monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.advance_scan(s_tdata[0]);
      if (m_tvalid && m_tready) begin
        sb.match_sample('{x_mv: m_tdata[14:0], y_mv: m_tdata[29:15],
                          camera_trigger: m_tdata[30], line_end: m_tlast,
                          volume_end: m_tuser});
      end
    end
  end

  // result side: random stall bursts, plus a long hold-off on request
  initial begin : result_sink
    int sink_gap;
    sink_gap = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else if (sink_gap > 0) begin
        m_tready <= 1'b0;
        sink_gap--;
      end else if (!calm && $urandom_range(0, 99) < 6) begin
        m_tready <= 1'b0;
        sink_gap = $urandom_range(0, 16);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one request, with an optional idle burst first
  task automatic send_request(bit restart);
    int gap;
    if (!calm && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_requests(int count, int restart_pct);
    repeat (count) send_request($urandom_range(0, 99) < restart_pct);
  endtask

  // stop offering and wait for every due sample, with a guard
  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.due_samples.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(rsw_pkg::reg_idx_t idx, logic [14:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // new setting, written only once the block is idle
  task automatic apply_config(int lp, int fb, int nf, int vm,
                              int ax, int ox, int ay, int oy);
    wait_drained();
    write_register(rsw_pkg::REG_LINE_POINTS, 15'(lp));
    write_register(rsw_pkg::REG_FLYBACK_POINTS, 15'(fb));
    write_register(rsw_pkg::REG_FRAMES_PER_VOLUME, 15'(nf));
    write_register(rsw_pkg::REG_VOLUME_MODE, 15'(vm));
    write_register(rsw_pkg::REG_X_AMPLITUDE, 15'(ax));
    write_register(rsw_pkg::REG_X_OFFSET, 15'(ox));
    write_register(rsw_pkg::REG_Y_AMPLITUDE, 15'(ay));
    write_register(rsw_pkg::REG_Y_OFFSET, 15'(oy));
    settings++;
  endtask

  // random setting, mostly short lines and small volumes; the narrow
  // registers sometimes get junk above their width
  task automatic pick_random_config();
    int lp, fb, nf, vm, ax, ox, ay, oy, roll;
    bit junk;
    roll = $urandom_range(0, 99);
    lp = (roll < 75) ? $urandom_range(8, 70) :
         (roll < 85) ? $urandom_range(0, 7) : $urandom_range(71, 16383);
    roll = $urandom_range(0, 99);
    fb = (roll < 80) ? $urandom_range(1, 30) :
         (roll < 90) ? 0 : $urandom_range(31, 2047);
    roll = $urandom_range(0, 99);
    nf = (roll < 70) ? $urandom_range(5, 12) :
         (roll < 85) ? $urandom_range(0, 4) : $urandom_range(13, 8191);
    vm = ($urandom_range(0, 99) < 70);
    ax = $urandom_range(0, 1) ? $urandom_range(0, 20000) : $urandom_range(0, 32767);
    ay = $urandom_range(0, 1) ? $urandom_range(0, 20000) : $urandom_range(0, 32767);
    ox = $urandom_range(0, 1) ? $urandom_range(0, 20000) - 10000 : $urandom & 32'h7FFF;
    oy = $urandom_range(0, 1) ? $urandom_range(0, 20000) - 10000 : $urandom & 32'h7FFF;
    junk = ($urandom_range(0, 4) == 0);
    if (junk) begin
      lp = lp | 32'h4000;
      fb = fb | ($urandom & 32'h7800);
      nf = nf | ($urandom & 32'h6000);
      vm = vm | ($urandom & 32'h7FFE);
    end
    apply_config(lp, fb, nf, vm, ax, ox, ay, oy);
  endtask

  // stimulus
  initial begin
    sb        = new();
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = rsw_pkg::REG_LINE_POINTS;
    cfg_data  = '0;
    sink_hold = 0;
    calm      = 1'b0;
    settings  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: start of a line, trigger edge, restart mid-line
    send_request(1'b1);
    repeat (11) send_request(1'b0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);

    // full volume with both outputs driven past the rails
    apply_config(24, 4, 5, 1, 20000, 10000, 20000, -10000);
    send_request(1'b1);
    run_requests(150, 0);

    // line of 8 points, no frames (all down frames), widest raw values
    apply_config(8, 1, 0, 1, 32767, -16384, 32767, 16383);
    run_requests(40, 5);

    // no flyback (zero divisor) and a one-step staircase
    apply_config(45, 0, 4, 1, 1, -1, 3, 1);
    send_request(1'b1);
    run_requests(190, 0);

    // longest line, over-long sum and frame count clamped
    apply_config(16383, 2047, 8191, 1, 20000, 0, 20000, 0);
    send_request(1'b1);
    run_requests(50, 0);

    // line of one sample, no more frames than the down ramp
    apply_config(0, 0, 3, 1, 20000, -10000, 20000, 10000);
    run_requests(20, 10);

    // run deep into a volume, then shrink frames under it, then shorten the line in line mode
    apply_config(10, 2, 12, 1, 5000, 100, 7000, -200);
    send_request(1'b1);
    run_requests(110, 0);
    apply_config(60, 5, 5, 1, 8000, -300, 9000, 400);
    run_requests(100, 0);
    apply_config(9, 1, 5, 0, 12000, 2000, 4000, -3000);
    run_requests(40, 0);

    // random settings; the second one holds the result side off for long
    for (int p = 0; p < 12; p++) begin
      if (p == 9) begin
        wait_drained();
        calm = 1'b1;
      end
      pick_random_config();
      if (p == 1) begin
        run_requests(5, 3);
        sink_hold = 700;
      end
      run_requests((p == 1) ? 30 : 35, 3);
    end

    // final drain, then quiet before the closing check
    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.due_samples.size() != 0) begin
      $error("%0d samples never came out", sb.due_samples.size());
      sb.errors++;
    end

    $display("Scan run: %0d requests (%0d restarts) over %0d register settings.",
             sb.requests, sb.restarts, settings);
    $display("Checked %0d samples, %0d line ends and %0d volume ends, %0d errors.",
             sb.checked, sb.line_ends, sb.volume_ends, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rsw_pkg.sv
src/rsw_term.sv
src/rsw_div.sv
src/raster_scan_waveform_generator.sv
tb/testbench.sv
